// ===== hdl/plfc_pkg.sv =====
package plfc_pkg;

   // Event codes carried in the command field.
   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_BUTTON  = 2'd1,
      CMD_CONTROL = 2'd2
   } command_type;

   // Register indexes of the configuration port.
   typedef enum logic [3:0] {
      REG_STRAIGHT_DUTY   = 4'd0,
      REG_DUTY_LIMIT      = 4'd1,
      REG_SPIN_DUTY       = 4'd2,
      REG_GAIN_P          = 4'd3,
      REG_GAIN_I          = 4'd4,
      REG_GAIN_D          = 4'd5,
      REG_WINDUP_LIMIT    = 4'd6,
      REG_MIN_PRESS_TICKS = 4'd7
   } csr_reg_type;

   // What the back end has to do with one word.
   typedef enum logic [2:0] {
      DRV_NONE,
      DRV_STOP,
      DRV_BASE,
      DRV_TURN_NEG,
      DRV_TURN_POS,
      DRV_PID
   } drive_op_type;

   localparam int unsigned CROSSINGS_TO_STOP_DEFAULT = 4;
   localparam int unsigned CROSS_MAX = 7;
   localparam int unsigned FAST_BLINK = 100;
   localparam int unsigned SLOW_BLINK = 500;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [9:0]  STRAIGHT_DUTY_RST   = 10'd400;
   localparam logic [9:0]  DUTY_LIMIT_RST      = 10'd650;
   localparam logic [9:0]  SPIN_DUTY_RST       = 10'd300;
   localparam logic [9:0]  GAIN_P_RST          = 10'd50;
   localparam logic [9:0]  GAIN_I_RST          = 10'd0;
   localparam logic [9:0]  GAIN_D_RST          = 10'd200;
   localparam logic [9:0]  WINDUP_LIMIT_RST    = 10'd150;
   localparam logic [15:0] MIN_PRESS_TICKS_RST = 16'd50;

   // Configuration register file contents.
   typedef struct packed {
      logic [9:0]  straight_duty;
      logic [9:0]  duty_limit;
      logic [9:0]  spin_duty;
      logic [9:0]  gain_p;
      logic [9:0]  gain_i;
      logic [9:0]  gain_d;
      logic [9:0]  windup_limit;
      logic [15:0] min_press_ticks;
   } cfg_type;

   // One classified word handed from the front end to the back end.
   typedef struct packed {
      drive_op_type op;
      logic [2:0]   err;
      logic [11:0]  err_sum;
      logic [3:0]   deriv;
      logic         led;
      logic         running;
      logic [2:0]   crossings;
   } work_type;

endpackage

// ===== hdl/plfc_front.sv =====
module plfc_front #(
   parameter int unsigned CROSSINGS_TO_STOP = plfc_pkg::CROSSINGS_TO_STOP_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  plfc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  logic               q_ready,
   input  logic [1:0]         command,
   input  logic               button_level,
   input  logic               sensor_left,
   input  logic               sensor_middle,
   input  logic               sensor_right,
   output logic               push,
   output plfc_pkg::work_type work
);

   localparam logic [2:0] STOP_COUNT = 3'(CROSSINGS_TO_STOP);
   localparam logic [2:0] CROSS_SAT = 3'(plfc_pkg::CROSS_MAX);
   localparam logic [9:0] FAST_LIMIT = 10'(plfc_pkg::FAST_BLINK);
   localparam logic [9:0] SLOW_LIMIT = 10'(plfc_pkg::SLOW_BLINK);

   logic [31:0]        time_ff, time_in;
   logic [31:0]        stamp_ff, stamp_in;
   logic               run_ff, run_in;
   logic [9:0]         blink_ff, blink_in;
   logic               led_ff, led_in;
   logic signed [2:0]  prev_ff, prev_in;
   logic signed [11:0] sum_ff, sum_in;
   logic [2:0]         cross_ff, cross_in;
   logic               on_cross_ff, on_cross_in;

   logic [9:0]         blink_next;
   logic [31:0]        press_len;
   logic signed [2:0]  err;
   logic signed [12:0] sum_wide;
   logic signed [12:0] lim_pos;
   logic signed [12:0] lim_neg;
   logic signed [11:0] sum_clamped;
   logic signed [3:0]  deriv;
   logic [2:0]         cross_hit;

   assign push = in_valid && q_ready;

   // Shared arithmetic for the step.
   assign blink_next = blink_ff + 10'd1;
   assign press_len = time_ff - stamp_ff;
   assign cross_hit = (!on_cross_ff && (cross_ff < CROSS_SAT)) ? cross_ff + 3'd1 : cross_ff;

   // Line position: left -2, left with middle -1, middle 0, right with middle +1, right +2.
   always_comb begin
      if (sensor_left) begin
         err = sensor_middle ? -3'sd1 : -3'sd2;
      end else if (sensor_right) begin
         err = sensor_middle ? 3'sd1 : 3'sd2;
      end else begin
         err = 3'sd0;
      end
   end

   // Integral with symmetric windup clamp, and error change.
   assign sum_wide = {sum_ff[11], sum_ff} + {{10{err[2]}}, err};
   assign lim_pos = $signed({3'b000, cfg.windup_limit});
   assign lim_neg = -lim_pos;
   always_comb begin
      if (sum_wide > lim_pos) begin
         sum_clamped = lim_pos[11:0];
      end else if (sum_wide < lim_neg) begin
         sum_clamped = lim_neg[11:0];
      end else begin
         sum_clamped = sum_wide[11:0];
      end
   end
   assign deriv = {err[2], err} - {prev_ff[2], prev_ff};

   // Next state and classification of the incoming word.
   always_comb begin
      time_in = time_ff;
      stamp_in = stamp_ff;
      run_in = run_ff;
      blink_in = blink_ff;
      led_in = led_ff;
      prev_in = prev_ff;
      sum_in = sum_ff;
      cross_in = cross_ff;
      on_cross_in = on_cross_ff;
      work.op = plfc_pkg::DRV_NONE;
      work.err = err;
      work.err_sum = sum_clamped;
      work.deriv = deriv;
      case (plfc_pkg::command_type'(command))
         plfc_pkg::CMD_TICK: begin
            if (blink_next >= (run_ff ? FAST_LIMIT : SLOW_LIMIT)) begin
               led_in = !led_ff;
               blink_in = '0;
            end else begin
               blink_in = blink_next;
            end
            time_in = time_ff + 32'd1;
         end
         plfc_pkg::CMD_BUTTON: begin
            if (!button_level) begin
               stamp_in = time_ff;
            end else if (press_len >= {16'd0, cfg.min_press_ticks}) begin
               run_in = !run_ff;
               if (!run_ff) begin
                  cross_in = '0;
                  on_cross_in = 1'b0;
                  prev_in = '0;
                  sum_in = '0;
               end
            end
         end
         plfc_pkg::CMD_CONTROL: begin
            work.op = plfc_pkg::DRV_STOP;
            if (run_ff) begin
               if (sensor_left && sensor_right) begin
                  // Crossing: counted once on entry, stop when enough are seen.
                  cross_in = cross_hit;
                  on_cross_in = 1'b1;
                  if (cross_hit >= STOP_COUNT) begin
                     run_in = 1'b0;
                  end else begin
                     prev_in = '0;
                     sum_in = '0;
                     work.op = plfc_pkg::DRV_BASE;
                  end
               end else if (!sensor_left && !sensor_middle && !sensor_right) begin
                  // Line lost: spin toward the side it was last seen on, or stop if it was last centred.
                  on_cross_in = 1'b0;
                  if (prev_ff < 0) begin
                     work.op = plfc_pkg::DRV_TURN_NEG;
                  end else if (prev_ff > 0) begin
                     work.op = plfc_pkg::DRV_TURN_POS;
                  end
               end else begin
                  if (!sensor_left && !sensor_right) begin
                     on_cross_in = 1'b0;
                  end
                  sum_in = sum_clamped;
                  prev_in = err;
                  work.op = plfc_pkg::DRV_PID;
               end
            end
         end
         default: begin
         end
      endcase
      work.led = led_in;
      work.running = run_in;
      work.crossings = cross_in;
   end

   // State registers, updated on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         stamp_ff <= '0;
         run_ff <= 1'b0;
         blink_ff <= '0;
         led_ff <= 1'b0;
         prev_ff <= '0;
         sum_ff <= '0;
         cross_ff <= '0;
         on_cross_ff <= 1'b0;
      end else if (push) begin
         time_ff <= time_in;
         stamp_ff <= stamp_in;
         run_ff <= run_in;
         blink_ff <= blink_in;
         led_ff <= led_in;
         prev_ff <= prev_in;
         sum_ff <= sum_in;
         cross_ff <= cross_in;
         on_cross_ff <= on_cross_in;
      end
   end

endmodule

// ===== hdl/plfc_queue.sv =====
module plfc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  plfc_pkg::work_type push_word,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output plfc_pkg::work_type head_word
);

   localparam int unsigned PW = plfc_pkg::QUEUE_PTR_W;
   localparam int unsigned DEPTH = plfc_pkg::QUEUE_DEPTH;

   plfc_pkg::work_type slot_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PW:0]        count_ff, count_in;

   assign not_full = count_ff != (PW + 1)'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_word = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (PW + 1)'(push) - (PW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/plfc_back.sv =====
module plfc_back (
   input  logic               clock,
   input  logic               reset,
   input  plfc_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  plfc_pkg::work_type q_word,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               drive_valid,
   output logic signed [10:0] left_drive,
   output logic signed [10:0] right_drive,
   output logic               led_on,
   output logic               running,
   output logic [2:0]         crossings
);

   logic                  a_valid_ff, a_valid_in;
   plfc_pkg::work_type    a_word_ff;
   logic signed [13:0]    prod_p_ff, prod_p_in;
   logic signed [21:0]    prod_i_ff, prod_i_in;
   logic signed [13:0]    prod_d_ff, prod_d_in;
   logic                  o_valid_ff, o_valid_in;
   logic                  dv_ff, dv_in;
   logic signed [10:0]    ld_ff, ld_in;
   logic signed [10:0]    rd_ff, rd_in;
   logic                  led_ff;
   logic                  run_ff;
   logic [2:0]            cross_ff;

   logic                  adv_out;
   logic                  a_load;
   logic signed [22:0]    u_sum;
   logic signed [23:0]    base_w;
   logic signed [23:0]    max_w;
   logic signed [23:0]    l_wide;
   logic signed [23:0]    r_wide;
   logic signed [10:0]    l_pid;
   logic signed [10:0]    r_pid;
   logic signed [10:0]    turn_w;

   // Pipeline advance: the output register frees when its word is taken.
   assign adv_out = !o_valid_ff || out_ready;
   assign a_load = q_valid && (!a_valid_ff || adv_out);
   assign pop = a_load;
   assign a_valid_in = a_load || (a_valid_ff && !adv_out);
   assign o_valid_in = (a_valid_ff && adv_out) || (o_valid_ff && !out_ready);

   // First stage: the three gain products.
   assign prod_p_in = 14'($signed({1'b0, cfg.gain_p})) * 14'($signed(q_word.err));
   assign prod_i_in = 22'($signed({1'b0, cfg.gain_i})) * 22'($signed(q_word.err_sum));
   assign prod_d_in = 14'($signed({1'b0, cfg.gain_d})) * 14'($signed(q_word.deriv));

   // Second stage: control sum, wheel mix and clamp to 0..duty_limit.
   assign u_sum = 23'(prod_i_ff) + 23'(prod_p_ff) + 23'(prod_d_ff);
   assign base_w = $signed({14'd0, cfg.straight_duty});
   assign max_w = $signed({14'd0, cfg.duty_limit});
   assign l_wide = base_w + 24'(u_sum);
   assign r_wide = base_w - 24'(u_sum);
   assign turn_w = $signed({1'b0, cfg.spin_duty});

   always_comb begin
      if (l_wide > max_w) begin
         l_pid = max_w[10:0];
      end else if (l_wide < 0) begin
         l_pid = '0;
      end else begin
         l_pid = l_wide[10:0];
      end
      if (r_wide > max_w) begin
         r_pid = max_w[10:0];
      end else if (r_wide < 0) begin
         r_pid = '0;
      end else begin
         r_pid = r_wide[10:0];
      end
   end

   // Drive selection by operation.
   always_comb begin
      dv_in = 1'b1;
      ld_in = '0;
      rd_in = '0;
      case (a_word_ff.op)
         plfc_pkg::DRV_NONE: begin
            dv_in = 1'b0;
         end
         plfc_pkg::DRV_STOP: begin
         end
         plfc_pkg::DRV_BASE: begin
            ld_in = base_w[10:0];
            rd_in = base_w[10:0];
         end
         plfc_pkg::DRV_TURN_NEG: begin
            ld_in = -turn_w;
            rd_in = turn_w;
         end
         plfc_pkg::DRV_TURN_POS: begin
            ld_in = turn_w;
            rd_in = -turn_w;
         end
         plfc_pkg::DRV_PID: begin
            ld_in = l_pid;
            rd_in = r_pid;
         end
         default: begin
            dv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_word_ff <= q_word;
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
      if (a_valid_ff && adv_out) begin
         dv_ff <= dv_in;
         ld_ff <= ld_in;
         rd_ff <= rd_in;
         led_ff <= a_word_ff.led;
         run_ff <= a_word_ff.running;
         cross_ff <= a_word_ff.crossings;
      end
   end

   assign out_valid = o_valid_ff;
   assign drive_valid = dv_ff;
   assign left_drive = ld_ff;
   assign right_drive = rd_ff;
   assign led_on = led_ff;
   assign running = run_ff;
   assign crossings = cross_ff;

endmodule

// ===== hdl/pid_line_follower_controller.sv =====
// An accepted word passes the two-entry queue, then the product and output registers.
// Throughput: one word per cycle while rsp_ready is high; the front end updates
// all state in the accept cycle; the back end has product and mix/clamp stages.
// Reset is synchronous and active high: configuration returns to its default values,
// and time, blink, button, run, crossing and regulator state all clear at once.
module pid_line_follower_controller #(
   parameter int unsigned CROSSINGS_TO_STOP = plfc_pkg::CROSSINGS_TO_STOP_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic               req_button_level,
   input  logic               req_sensor_left,
   input  logic               req_sensor_middle,
   input  logic               req_sensor_right,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_drive_valid,
   output logic signed [10:0] rsp_left_drive,
   output logic signed [10:0] rsp_right_drive,
   output logic               rsp_led_on,
   output logic               rsp_running,
   output logic [2:0]         rsp_crossings
);

   plfc_pkg::cfg_type  cfg_ff, cfg_in;
   plfc_pkg::work_type front_word;
   plfc_pkg::work_type head_word;
   logic               push;
   logic               q_not_full;
   logic               q_not_empty;
   logic               pop;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (plfc_pkg::csr_reg_type'(csr_index))
            plfc_pkg::REG_STRAIGHT_DUTY:   cfg_in.straight_duty = csr_data[9:0];
            plfc_pkg::REG_DUTY_LIMIT:      cfg_in.duty_limit = csr_data[9:0];
            plfc_pkg::REG_SPIN_DUTY:       cfg_in.spin_duty = csr_data[9:0];
            plfc_pkg::REG_GAIN_P:          cfg_in.gain_p = csr_data[9:0];
            plfc_pkg::REG_GAIN_I:          cfg_in.gain_i = csr_data[9:0];
            plfc_pkg::REG_GAIN_D:          cfg_in.gain_d = csr_data[9:0];
            plfc_pkg::REG_WINDUP_LIMIT:    cfg_in.windup_limit = csr_data[9:0];
            plfc_pkg::REG_MIN_PRESS_TICKS: cfg_in.min_press_ticks = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.straight_duty <= plfc_pkg::STRAIGHT_DUTY_RST;
         cfg_ff.duty_limit <= plfc_pkg::DUTY_LIMIT_RST;
         cfg_ff.spin_duty <= plfc_pkg::SPIN_DUTY_RST;
         cfg_ff.gain_p <= plfc_pkg::GAIN_P_RST;
         cfg_ff.gain_i <= plfc_pkg::GAIN_I_RST;
         cfg_ff.gain_d <= plfc_pkg::GAIN_D_RST;
         cfg_ff.windup_limit <= plfc_pkg::WINDUP_LIMIT_RST;
         cfg_ff.min_press_ticks <= plfc_pkg::MIN_PRESS_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: event handling and classification.
   assign req_ready = q_not_full;

   plfc_front #(
      .CROSSINGS_TO_STOP(CROSSINGS_TO_STOP)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(req_valid),
      .q_ready(q_not_full),
      .command(req_command),
      .button_level(req_button_level),
      .sensor_left(req_sensor_left),
      .sensor_middle(req_sensor_middle),
      .sensor_right(req_sensor_right),
      .push(push),
      .work(front_word)
   );

   // Queue between the two halves.
   plfc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_word(front_word),
      .not_full(q_not_full),
      .pop(pop),
      .not_empty(q_not_empty),
      .head_word(head_word)
   );

   // Back end: wheel drive arithmetic and output register.
   plfc_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_valid(q_not_empty),
      .q_word(head_word),
      .pop(pop),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .drive_valid(rsp_drive_valid),
      .left_drive(rsp_left_drive),
      .right_drive(rsp_right_drive),
      .led_on(rsp_led_on),
      .running(rsp_running),
      .crossings(rsp_crossings)
   );

   // A word without new drives carries zero drives.
   a_idle_drives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_valid |-> rsp_left_drive == 11'sd0 && rsp_right_drive == 11'sd0)
      else $error("drives not zero on a word without drive update");

   // While stopped, every drive update is a stop.
   a_stopped_drives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_valid && !rsp_running
         |-> rsp_left_drive == 11'sd0 && rsp_right_drive == 11'sd0)
      else $error("nonzero drive while stopped");

   // A reverse wheel only appears in a symmetric spin.
   a_spin_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_valid && rsp_left_drive < 0 |-> rsp_right_drive == -rsp_left_drive)
      else $error("asymmetric spin");

   // Crossing count never passes the stop count.
   a_cross_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_crossings <= 3'(CROSSINGS_TO_STOP))
      else $error("crossing count beyond stop count");

endmodule
